// File: hw/rtl/hashed_key_table_assert.svh
// Assertion macros used by the hashed key table back end
`ifndef HASHED_KEY_TABLE_ASSERT_SVH
`define HASHED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset
`define HKT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset
`define HKT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/hkt_pkg.sv
// Shared constants for the hashed key table
package hkt_pkg;
   localparam logic [31:0] HASH_SEED = 32'd5381;
   localparam int HASH_BITS = 32;
   localparam int ID_BITS = 11;
   localparam int ID_OFFSET = 2;

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_CREATE = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_TOO_LONG  = 3'd4;

   typedef enum logic [4:0] {
      BK_CLEAR = 5'b00001,
      BK_IDLE  = 5'b00010,
      BK_MOD   = 5'b00100,
      BK_READ  = 5'b01000,
      BK_CHECK = 5'b10000
   } back_state_type;
endpackage

// File: hw/rtl/hkt_ram.sv
// Generic simple dual-port RAM with registered read
module hkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/hkt_queue.sv
// Two-entry job queue between the front and back ends
module hkt_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: hw/rtl/hkt_front.sv
// Front end: collects key bytes, hashes them and queues one job per key
module hkt_front #(
   parameter int KEY_BYTES = 32,
   parameter int JOB_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_key_byte,
   input  logic             req_key_last,
   output logic             job_push,
   output logic [JOB_W-1:0] job_data,
   input  logic             job_ready
);
   localparam int LW = $clog2(KEY_BYTES + 1);
   localparam int BI = $clog2(KEY_BYTES);
   localparam int KW = KEY_BYTES * 8;

   logic [31:0]   hash_ff, hash_in, hash_nx;
   logic [LW-1:0] len_ff, len_in, len_nx;
   logic          ovf_ff, ovf_in, ovf_nx;
   logic [7:0]    buf_ff [KEY_BYTES];
   logic [KW-1:0] key_packed;
   logic          room, xfer;

   assign req_ready = job_ready || !req_key_last;
   assign xfer      = req_valid && req_ready;
   assign job_push  = xfer && req_key_last;

   always_comb begin
      hash_nx = (hash_ff << 5) + hash_ff + {24'd0, req_key_byte};
      room    = (len_ff < LW'(KEY_BYTES));
      len_nx  = room ? len_ff + LW'(1) : len_ff;
      ovf_nx  = ovf_ff || !room;
      for (int i = 0; i < KEY_BYTES; i++) begin
         // merge the current byte, zero bytes past the key end
         if (LW'(i) >= len_nx) begin
            key_packed[i*8 +: 8] = 8'd0;
         end else if (room && (len_ff[BI-1:0] == BI'(i))) begin
            key_packed[i*8 +: 8] = req_key_byte;
         end else begin
            key_packed[i*8 +: 8] = buf_ff[i];
         end
      end
      job_data = {req_kind, ovf_nx, len_nx, hash_nx, key_packed};
      hash_in  = hash_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      if (xfer) begin
         if (req_key_last) begin
            hash_in = hkt_pkg::HASH_SEED;
            len_in  = '0;
            ovf_in  = 1'b0;
         end else begin
            hash_in = hash_nx;
            len_in  = len_nx;
            ovf_in  = ovf_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= hkt_pkg::HASH_SEED;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
      end
      if (xfer && room) begin
         buf_ff[len_ff[BI-1:0]] <= req_key_byte;
      end
   end
endmodule

// File: hw/rtl/hkt_back.sv
// Back end: table clear after reset, home slot reduction, table probe and result register
module hkt_back #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int KEY_BYTES = 32,
   parameter int JOB_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  logic [JOB_W-1:0] job_data,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [10:0]      rsp_object_id
);
   `include "hashed_key_table_assert.svh"

   localparam int LW = $clog2(KEY_BYTES + 1);
   localparam int KW = KEY_BYTES * 8;
   localparam int SW = $clog2(TABLE_ENTRIES);
   localparam int RW = 1 + LW + KW;
   localparam int IW = (SW + 1 > hkt_pkg::ID_BITS) ? SW + 1 : hkt_pkg::ID_BITS;
   localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
   localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_ENTRIES - 1);
   localparam int RK = 31 + SW;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << RK) / 64'(TABLE_ENTRIES);
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];

   hkt_pkg::back_state_type state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [31:0]   hash_ff, hash_in;
   logic [LW-1:0] len_ff, len_in;
   logic [KW-1:0] key_ff, key_in;
   logic [31:0]   quo_ff, quo_in;
   logic [1:0]    step_ff, step_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic          rv_ff, rv_in;
   logic [2:0]    st_ff, st_in;
   logic [10:0]   id_ff, id_in;

   logic          wr_en, rd_en;
   logic [SW-1:0] wr_addr;
   logic [RW-1:0] wr_data, rd_data;
   logic          e_valid, match;
   logic [LW-1:0] e_len;
   logic [KW-1:0] e_key;
   logic [63:0]   prod;
   logic [31:0]   rem_raw, rem_fix;
   logic [IW-1:0] id_full;

   hkt_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(slot_ff),
      .rd_data(rd_data)
   );

   assign e_valid = rd_data[RW-1];
   assign e_len   = rd_data[KW +: LW];
   assign e_key   = rd_data[KW-1:0];
   assign match   = e_valid && (e_len == len_ff) && (e_key == key_ff);
   assign id_full = IW'(slot_ff) + IW'(hkt_pkg::ID_OFFSET);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      hash_in  = hash_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      slot_in  = slot_ff;
      cnt_in   = cnt_ff;
      clr_in   = clr_ff;
      rv_in    = rv_ff && !rsp_ready;
      st_in    = st_ff;
      id_in    = id_ff;
      job_pop  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = slot_ff;
      wr_data  = {1'b1, len_ff, key_ff};
      rd_en    = 1'b0;
      prod     = {32'd0, hash_ff} * {32'd0, RECIP};
      rem_raw  = hash_ff - quo_ff;
      rem_fix  = (rem_raw >= 32'(TABLE_ENTRIES)) ? rem_raw - 32'(TABLE_ENTRIES) : rem_raw;
      case (state_ff)
         hkt_pkg::BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + SW'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = hkt_pkg::BK_IDLE;
            end
         end
         hkt_pkg::BK_IDLE: begin
            if (job_valid && !rv_ff) begin
               job_pop = 1'b1;
               key_in  = job_data[KW-1:0];
               hash_in = job_data[KW +: 32];
               len_in  = job_data[KW+32 +: LW];
               kind_in = job_data[JOB_W-1 -: 2];
               step_in = '0;
               if (job_data[KW+32+LW]) begin
                  rv_in = 1'b1;
                  st_in = hkt_pkg::ST_TOO_LONG;
                  id_in = '0;
               end else if (IS_POW2) begin
                  slot_in  = job_data[KW +: SW];
                  cnt_in   = '0;
                  state_in = hkt_pkg::BK_READ;
               end else begin
                  state_in = hkt_pkg::BK_MOD;
               end
            end
         end
         hkt_pkg::BK_MOD: begin
            // reciprocal reduction: estimate quotient, multiply back, subtract and correct
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd0) begin
               quo_in = 32'(prod >> RK);
            end else if (step_ff == 2'd1) begin
               quo_in = quo_ff * 32'(TABLE_ENTRIES);
            end else begin
               slot_in  = rem_fix[SW-1:0];
               cnt_in   = '0;
               state_in = hkt_pkg::BK_READ;
            end
         end
         hkt_pkg::BK_READ: begin
            rd_en    = 1'b1;
            state_in = hkt_pkg::BK_CHECK;
         end
         hkt_pkg::BK_CHECK: begin
            state_in = hkt_pkg::BK_IDLE;
            if (kind_ff == hkt_pkg::KIND_CREATE && !e_valid) begin
               wr_en = 1'b1;
               rv_in = 1'b1;
               st_in = hkt_pkg::ST_OK;
               id_in = id_full[10:0];
            end else if (match) begin
               rv_in = 1'b1;
               if (kind_ff == hkt_pkg::KIND_CREATE) begin
                  st_in = hkt_pkg::ST_DUPLICATE;
                  id_in = '0;
               end else begin
                  wr_en   = (kind_ff == hkt_pkg::KIND_REMOVE);
                  wr_data = {1'b0, len_ff, key_ff};
                  st_in   = hkt_pkg::ST_OK;
                  id_in   = id_full[10:0];
               end
            end else if (cnt_ff == LAST_SLOT) begin
               rv_in = 1'b1;
               st_in = (kind_ff == hkt_pkg::KIND_CREATE) ? hkt_pkg::ST_FULL
                                                         : hkt_pkg::ST_NOT_FOUND;
               id_in = '0;
            end else begin
               slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SW'(1);
               cnt_in   = cnt_ff + SW'(1);
               state_in = hkt_pkg::BK_READ;
            end
         end
         default: begin
            state_in = hkt_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkt_pkg::BK_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      kind_ff <= kind_in;
      hash_ff <= hash_in;
      len_ff  <= len_in;
      key_ff  <= key_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      slot_ff <= slot_in;
      cnt_ff  <= cnt_in;
      st_ff   <= st_in;
      id_ff   <= id_in;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_status    = st_ff;
   assign rsp_object_id = id_ff;

   `HKT_ASSERT_NOW(a_no_pop_in_clear, state_ff == hkt_pkg::BK_CLEAR, !job_pop)
   `HKT_ASSERT_NOW(a_write_states, wr_en,
      state_ff == hkt_pkg::BK_CLEAR || state_ff == hkt_pkg::BK_CHECK)
   `HKT_ASSERT_NEXT(a_check_after_read, state_ff == hkt_pkg::BK_READ,
      state_ff == hkt_pkg::BK_CHECK)
   `HKT_ASSERT_NOW(a_pop_needs_free_rsp, job_pop, !rv_ff)
endmodule

// File: hw/rtl/hashed_key_table.sv
// Top level of the hashed key table: front end, job queue, back end
//
//   channel | ports              | carries
//   req     | req_valid/ready    | kind, key_byte, key_last (one byte per transfer)
//   rsp     | rsp_valid/ready    | status, object_id (one per key)
//
// Only a key's last byte stalls, while the two-key queue is full. Per key the
// back end takes the job, reduces the hash to a home slot if TABLE_ENTRIES is
// not a power of two (else the low hash bits are the slot), then probes 1 to
// TABLE_ENTRIES slots, each a table RAM read and a check; a too-long key gets
// no probe. After reset a clearing pass empties the table; bytes are taken
// meanwhile until the queue fills. A held response stalls the back end.
module hashed_key_table #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int KEY_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_key_byte,
   input  logic        req_key_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [10:0] rsp_object_id
);
   localparam int LW = $clog2(KEY_BYTES + 1);
   localparam int JOB_W = 2 + 1 + LW + hkt_pkg::HASH_BITS + KEY_BYTES * 8;

   logic             push, push_ready, pop, pop_valid;
   logic [JOB_W-1:0] push_data, pop_data;

   hkt_front #(.KEY_BYTES(KEY_BYTES), .JOB_W(JOB_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_key_byte(req_key_byte),
      .req_key_last(req_key_last),
      .job_push    (push),
      .job_data    (push_data),
      .job_ready   (push_ready)
   );

   hkt_queue #(.WIDTH(JOB_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .push_ready(push_ready),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   hkt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BYTES(KEY_BYTES), .JOB_W(JOB_W)) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (pop_valid),
      .job_data     (pop_data),
      .job_pop      (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_object_id(rsp_object_id)
   );
endmodule

// File: tb/sv/tb_hashed_key_table.sv
// Self-checking testbench for the hashed key table: directed and random key traffic
module tb_hashed_key_table;
   localparam int SLOTS = 1024;
   localparam int MAX_KEY = 32;
   localparam int STALL_LIMIT = 40000;

   typedef struct {
      logic [7:0] b [40];
      int         len;
   } key_type;

   class table_scoreboard;
      logic [31:0] hash_acc;
      logic [7:0]  key_buf [MAX_KEY];
      int          key_len;
      bit          key_ovf;
      bit          live [SLOTS];
      logic [7:0]  slot_key [SLOTS][MAX_KEY];
      int          slot_len [SLOTS];
      int          used;
      logic [2:0]  status_q [$];
      logic [10:0] id_q [$];
      int          errors;
      int          results;
      int          status_seen [5];

      function new();
         hash_acc = hkt_pkg::HASH_SEED;
         key_len = 0;
         key_ovf = 0;
         used = 0;
         errors = 0;
         results = 0;
         foreach (live[i]) live[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function bit same_key(int s);
         if (slot_len[s] != key_len) return 0;
         for (int i = 0; i < key_len; i++)
            if (slot_key[s][i] != key_buf[i]) return 0;
         return 1;
      endfunction

      // Note one accepted key byte; on the last byte predict the result
      function void note_byte(logic [1:0] kind, logic [7:0] kb, logic last);
         int s;
         logic [2:0] st;
         int id;
         bit done;
         hash_acc = hash_acc * 33 + kb;
         if (key_len < MAX_KEY) begin
            key_buf[key_len] = kb;
            key_len++;
         end else begin
            key_ovf = 1;
         end
         if (!last) return;
         s = hash_acc % SLOTS;
         st = hkt_pkg::ST_OK;
         id = 0;
         done = 0;
         if (key_ovf) begin
            st = hkt_pkg::ST_TOO_LONG;
         end else if (kind == hkt_pkg::KIND_CREATE) begin
            for (int n = 0; n < SLOTS && !done; n++) begin
               if (!live[s]) begin
                  live[s] = 1;
                  used++;
                  slot_len[s] = key_len;
                  for (int i = 0; i < key_len; i++) slot_key[s][i] = key_buf[i];
                  id = s + hkt_pkg::ID_OFFSET;
                  done = 1;
               end else if (same_key(s)) begin
                  st = hkt_pkg::ST_DUPLICATE;
                  done = 1;
               end else begin
                  s = (s + 1) % SLOTS;
               end
            end
            if (!done) st = hkt_pkg::ST_FULL;
         end else begin
            // lookup, remove, and the unused kind that acts as a lookup
            for (int n = 0; n < SLOTS && !done; n++) begin
               if (live[s] && same_key(s)) begin
                  done = 1;
               end else begin
                  s = (s + 1) % SLOTS;
               end
            end
            if (done) begin
               id = s + hkt_pkg::ID_OFFSET;
               if (kind == hkt_pkg::KIND_REMOVE) begin
                  live[s] = 0;
                  used--;
               end
            end else begin
               st = hkt_pkg::ST_NOT_FOUND;
            end
         end
         status_q.push_back(st);
         id_q.push_back(id[10:0]);
         hash_acc = hkt_pkg::HASH_SEED;
         key_len = 0;
         key_ovf = 0;
      endfunction

      function void check_result(logic [2:0] st, logic [10:0] id);
         logic [2:0] es;
         logic [10:0] ei;
         if (status_q.size() == 0) begin
            $error("unexpected result: status %0d object_id %0d", st, id);
            errors++;
            return;
         end
         es = status_q.pop_front();
         ei = id_q.pop_front();
         results++;
         if (es <= hkt_pkg::ST_TOO_LONG) status_seen[es]++;
         if (st !== es) begin
            $error("status: expected %0d, actual %0d", es, st);
            errors++;
         end
         if (id !== ei) begin
            $error("object_id: expected %0d, actual %0d", ei, id);
            errors++;
         end
      endfunction

      function int pending();
         return status_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [7:0]  req_key_byte;
   logic        req_key_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [10:0] rsp_object_id;

   table_scoreboard sb;
   int idle_pct;
   int stall_pct;
   int bytes_sent;
   int quiet_cycles;
   key_type pool [$];

   hashed_key_table dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_key_byte(req_key_byte),
      .req_key_last(req_key_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_object_id(rsp_object_id)
   );

   initial clock = 0;
   always #10 clock = ~clock;

   // Observe transfers on both channels, drive rsp_ready, run the watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            sb.note_byte(req_kind, req_key_byte, req_key_last);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_status, rsp_object_id);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_hashed_key_table: FAIL");
            $finish;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [1:0] kind, input logic [7:0] kb, input logic last);
      req_valid <= 1;
      req_kind <= kind;
      req_key_byte <= kb;
      req_key_last <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic send_key(input logic [1:0] kind, input key_type k);
      for (int i = 0; i < k.len; i++)
         send_byte(kind, k.b[i], i == k.len - 1);
      if (kind == hkt_pkg::KIND_CREATE) pool.push_back(k);
   endtask

   function automatic key_type make_key(int len);
      key_type k;
      k.len = len;
      for (int i = 0; i < 40; i++) k.b[i] = 8'($urandom_range(255));
      return k;
   endfunction

   function automatic int home_of(key_type k);
      logic [31:0] h;
      h = hkt_pkg::HASH_SEED;
      for (int i = 0; i < k.len; i++) h = h * 33 + k.b[i];
      return h % SLOTS;
   endfunction

   task automatic directed_part();
      key_type k0, kff, klong, kmax, ka, kb;
      k0 = make_key(1);
      k0.b[0] = 8'h00;
      kff = make_key(1);
      kff.b[0] = 8'hFF;
      kmax = make_key(MAX_KEY);
      klong = make_key(MAX_KEY + 1);
      send_key(hkt_pkg::KIND_LOOKUP, k0);
      send_key(hkt_pkg::KIND_CREATE, k0);
      send_key(hkt_pkg::KIND_CREATE, kff);
      send_key(hkt_pkg::KIND_LOOKUP, kff);
      send_key(hkt_pkg::KIND_CREATE, k0);
      send_key(2'd3, k0);
      send_key(hkt_pkg::KIND_REMOVE, k0);
      send_key(hkt_pkg::KIND_REMOVE, k0);
      send_key(hkt_pkg::KIND_CREATE, kmax);
      send_key(hkt_pkg::KIND_LOOKUP, kmax);
      send_key(hkt_pkg::KIND_CREATE, klong);
      // Hidden duplicate: two keys sharing a home slot, remove the first
      ka = make_key(2);
      ka.b[0] = 8'h41;
      ka.b[1] = 8'h42;
      kb = ka;
      for (int i = 0; i < 65536; i++) begin
         kb.b[0] = i[15:8];
         kb.b[1] = i[7:0];
         if (home_of(kb) == home_of(ka) && i != 16'h4142) break;
      end
      send_key(hkt_pkg::KIND_CREATE, ka);
      send_key(hkt_pkg::KIND_CREATE, kb);
      send_key(hkt_pkg::KIND_REMOVE, ka);
      send_key(hkt_pkg::KIND_CREATE, kb);
      send_key(hkt_pkg::KIND_LOOKUP, kb);
   endtask

   task automatic random_part(int byte_budget);
      int stop_at;
      int pick;
      key_type k;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 30 && pool.size() > 0) begin
            send_key(2'($urandom_range(2)), pool[$urandom_range(pool.size() - 1)]);
         end else if (pick < 55 && pool.size() > 0) begin
            send_key(hkt_pkg::KIND_LOOKUP, pool[$urandom_range(pool.size() - 1)]);
         end else if (pick < 75) begin
            k = make_key($urandom_range(9) == 0 ? $urandom_range(MAX_KEY) + 1
                                                : $urandom_range(5) + 1);
            send_key(hkt_pkg::KIND_CREATE, k);
         end else begin
            // noise: any kind, lengths from one byte to past the limit
            k = make_key($urandom_range(MAX_KEY + 4) + 1);
            send_key(2'($urandom_range(3)), k);
         end
      end
   endtask

   task automatic fill_table();
      key_type k;
      key_type kone;
      int n;
      n = 0;
      while (sb.used < SLOTS && n < 4 * SLOTS) begin
         // one-byte keys first, then two-byte keys
         if (n < 256) begin
            k.len = 1;
            k.b[0] = n[7:0];
         end else begin
            k.len = 2;
            k.b[0] = n[15:8];
            k.b[1] = n[7:0];
         end
         send_key(hkt_pkg::KIND_CREATE, k);
         n++;
         // hold off until the table state settles before the next create
         req_valid <= 0;
         do @(posedge clock); while (sb.pending() > 0);
      end
      k = make_key(4);
      kone = make_key(1);
      kone.b[0] = 8'h05;
      send_key(hkt_pkg::KIND_CREATE, k);
      send_key(hkt_pkg::KIND_LOOKUP, k);
      send_key(hkt_pkg::KIND_REMOVE, kone);
      send_key(hkt_pkg::KIND_CREATE, k);
   endtask

   initial begin
      sb = new();
      idle_pct = 0;
      stall_pct = 0;
      bytes_sent = 0;
      reset <= 1;
      req_valid <= 0;
      req_kind <= hkt_pkg::KIND_LOOKUP;
      req_key_byte <= 0;
      req_key_last <= 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed_part();
      random_part(40);
      idle_pct = 54;
      random_part(40);
      idle_pct = 0;
      stall_pct = 54;
      random_part(40);
      idle_pct = 14;
      stall_pct = 14;
      random_part(40);
      idle_pct = 0;
      stall_pct = 0;
      fill_table();
      req_valid <= 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (2 * SLOTS + 100) @(posedge clock);
      $display("Covered %0d key bytes and %0d results: ok %0d, not found %0d,",
               bytes_sent, sb.results, sb.status_seen[0], sb.status_seen[1]);
      $display("duplicate %0d, table full %0d, key too long %0d.",
               sb.status_seen[2], sb.status_seen[3], sb.status_seen[4]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_hashed_key_table: PASS");
      end else begin
         $display("tb_hashed_key_table: FAIL");
      end
      $finish;
   end
endmodule
